FILE: src/cbcr_pkg.sv
package cbcr_pkg;

	// Fixed-point format of positions, velocities and the half side.
	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int RAD_IN_W  = 12;
	localparam int HALF_W    = 31;

	// Restitution is unsigned Q0.16; one extra bit holds 1.0 itself.
	localparam int REST_W = 17;
	localparam logic [REST_W-1:0] REST_ONE   = REST_W'(1 << 16);
	localparam logic [REST_W-1:0] REST_RESET = REST_W'(39322);

	// Radius in fixed point, its square, and the normal's magnitude width.
	localparam int RF_W  = RAD_IN_W + FRAC_BITS;
	localparam int D2_W  = 2 * RF_W;
	localparam int Q_W   = FRAC_BITS + 1;
	localparam int REM_W = RF_W + FRAC_BITS;

	// Width used for sums ahead of saturation.
	localparam int SAT_W = 40;

	typedef logic signed [WORD_W-1:0] word_t;

	// Everything about one pair that rides along with the arithmetic.
	typedef struct packed {
		word_t               cx;
		word_t               cy;
		word_t               cvx;
		word_t               cvy;
		word_t               bx;
		word_t               by;
		word_t               bvx;
		word_t               bvy;
		logic [RAD_IN_W-1:0] rad;
		logic [RF_W-1:0]     adx;
		logic [RF_W-1:0]     ady;
		logic                sdx;
		logic                sdy;
		logic                hit;
	} body_t;

	// Clamp a wide signed sum into the signed word range.
	function automatic word_t sat_word(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi_lim;
		logic signed [SAT_W-1:0] lo_lim;
		hi_lim = {{(SAT_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
		lo_lim = ~hi_lim;
		if (v > hi_lim) begin
			return hi_lim[WORD_W-1:0];
		end else if (v < lo_lim) begin
			return lo_lim[WORD_W-1:0];
		end
		return v[WORD_W-1:0];
	endfunction

endpackage

FILE: src/cbcr_if.sv
interface cbcr_item_if;
	import cbcr_pkg::*;

	logic                valid;
	logic                ready;
	word_t               circle_x;
	word_t               circle_y;
	word_t               circle_vx;
	word_t               circle_vy;
	logic [RAD_IN_W-1:0] circle_radius;
	word_t               box_x;
	word_t               box_y;
	logic [HALF_W-1:0]   box_half;
	word_t               box_vx;
	word_t               box_vy;

	modport source (
		output valid, circle_x, circle_y, circle_vx, circle_vy, circle_radius,
		output box_x, box_y, box_half, box_vx, box_vy,
		input  ready
	);
	modport sink (
		input  valid, circle_x, circle_y, circle_vx, circle_vy, circle_radius,
		input  box_x, box_y, box_half, box_vx, box_vy,
		output ready
	);
endinterface

interface cbcr_result_if;
	import cbcr_pkg::*;

	logic  valid;
	logic  ready;
	word_t new_circle_x;
	word_t new_circle_y;
	word_t new_circle_vx;
	word_t new_circle_vy;
	word_t new_box_x;
	word_t new_box_y;
	word_t new_box_vx;
	word_t new_box_vy;
	logic  overlap;
	logic  impulse_applied;

	modport source (
		output valid, new_circle_x, new_circle_y, new_circle_vx, new_circle_vy,
		output new_box_x, new_box_y, new_box_vx, new_box_vy, overlap, impulse_applied,
		input  ready
	);
	modport sink (
		input  valid, new_circle_x, new_circle_y, new_circle_vx, new_circle_vy,
		input  new_box_x, new_box_y, new_box_vx, new_box_vy, overlap, impulse_applied,
		output ready
	);
endinterface

interface cbcr_cfg_if;
	import cbcr_pkg::*;

	logic              valid;
	logic              ready;
	logic [REST_W-1:0] restitution;

	modport source (output valid, restitution, input ready);
	modport sink (input valid, restitution, output ready);
endinterface

FILE: src/cbcr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module cbcr_sqrt #(
	parameter type side_t = logic
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [cbcr_pkg::D2_W-1:0] rad,
	input  side_t                   in_side,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [cbcr_pkg::RF_W-1:0] root,
	output side_t                   out_side
);
	import cbcr_pkg::*;

	localparam int N = RF_W;

	logic [N:0]       en;
	logic             vld_s  [N];
	logic [D2_W-1:0]  num_s  [N];
	logic [D2_W-1:0]  res_s  [N];
	side_t            side_s [N];

	assign en[N]     = out_ready;
	assign in_ready  = en[0];
	assign out_valid = vld_s[N-1];
	assign root      = res_s[N-1][RF_W-1:0];
	assign out_side  = side_s[N-1];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [D2_W:0] BIT = (D2_W+1)'(1) << (2 * (N - 1 - k));

		logic            v_i;
		logic [D2_W-1:0] num_i;
		logic [D2_W-1:0] res_i;
		side_t           side_i;
		logic [D2_W:0]   trial;
		logic            take;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign num_i  = rad;
			assign res_i  = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = vld_s[k-1];
			assign num_i  = num_s[k-1];
			assign res_i  = res_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = {1'b0, res_i} + BIT;
		assign take  = {1'b0, num_i} >= trial;
		assign en[k] = !vld_s[k] || en[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				num_s[k]  <= take ? D2_W'({1'b0, num_i} - trial) : num_i;
				res_s[k]  <= take ? D2_W'(({1'b0, res_i} >> 1) + BIT) : (res_i >> 1);
				side_s[k] <= side_i;
			end
		end
	end

endmodule

FILE: src/cbcr_div.sv
// Two restoring dividers sharing one divisor, one quotient bit per stage.
module cbcr_div #(
	parameter type side_t = logic
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [cbcr_pkg::RF_W-1:0] num_x,
	input  logic [cbcr_pkg::RF_W-1:0] num_y,
	input  logic [cbcr_pkg::RF_W-1:0] den,
	input  side_t                    in_side,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [cbcr_pkg::Q_W-1:0]  quo_x,
	output logic [cbcr_pkg::Q_W-1:0]  quo_y,
	output logic [cbcr_pkg::RF_W-1:0] out_den,
	output side_t                    out_side
);
	import cbcr_pkg::*;

	localparam int N = Q_W;

	logic [N:0]       en;
	logic             vld_s   [N];
	logic [REM_W-1:0] rem_x_s [N];
	logic [REM_W-1:0] rem_y_s [N];
	logic [Q_W-1:0]   q_x_s   [N];
	logic [Q_W-1:0]   q_y_s   [N];
	logic [RF_W-1:0]  den_s   [N];
	side_t            side_s  [N];

	assign en[N]     = out_ready;
	assign in_ready  = en[0];
	assign out_valid = vld_s[N-1];
	assign quo_x     = q_x_s[N-1];
	assign quo_y     = q_y_s[N-1];
	assign out_den   = den_s[N-1];
	assign out_side  = side_s[N-1];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic             v_i;
		logic [REM_W-1:0] rx_i;
		logic [REM_W-1:0] ry_i;
		logic [Q_W-1:0]   qx_i;
		logic [Q_W-1:0]   qy_i;
		logic [RF_W-1:0]  d_i;
		side_t            side_i;
		logic [REM_W-1:0] trial;
		logic             take_x;
		logic             take_y;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rx_i   = {num_x, {FRAC_BITS{1'b0}}};
			assign ry_i   = {num_y, {FRAC_BITS{1'b0}}};
			assign qx_i   = '0;
			assign qy_i   = '0;
			assign d_i    = den;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = vld_s[k-1];
			assign rx_i   = rem_x_s[k-1];
			assign ry_i   = rem_y_s[k-1];
			assign qx_i   = q_x_s[k-1];
			assign qy_i   = q_y_s[k-1];
			assign d_i    = den_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial  = REM_W'(d_i) << (N - 1 - k);
		assign take_x = rx_i >= trial;
		assign take_y = ry_i >= trial;
		assign en[k]  = !vld_s[k] || en[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_x_s[k] <= take_x ? (rx_i - trial) : rx_i;
				rem_y_s[k] <= take_y ? (ry_i - trial) : ry_i;
				q_x_s[k]   <= {qx_i[Q_W-2:0], take_x};
				q_y_s[k]   <= {qy_i[Q_W-2:0], take_y};
				den_s[k]   <= d_i;
				side_s[k]  <= side_i;
			end
		end
	end

endmodule

FILE: src/circle_box_collision_resolve.sv
// Throughput: one word per cycle unless the result side stalls; the 28-stage
// square root and the 17-stage normal divider are fully pipelined, so each
// stage holds its own pair.
// Reset (arst_n low, asynchronous) empties every stage and sets restitution to 39322.
// A stalled output holds its word while earlier stages keep closing up bubbles.
module circle_box_collision_resolve (
	input  logic          clk,
	input  logic          arst_n,
	cbcr_item_if.sink     item,
	cbcr_result_if.source result,
	cbcr_cfg_if.sink      cfg
);
	import cbcr_pkg::*;

	// Offset of the circle centre from the nearest point of the square.
	localparam int OFF_W = WORD_W + 3;
	// Relative normal speed: 33-bit velocity difference times 18-bit normal, summed.
	localparam int RV_W  = WORD_W + 1;
	localparam int NS_W  = Q_W + 1;
	localparam int SV_W  = RV_W + NS_W;
	localparam int S_W   = SV_W + 1;
	localparam int VAN_W = S_W - 1 - FRAC_BITS;
	// Impulse magnitude and its projection onto the normal.
	localparam int FAC_W = REST_W + 1;
	localparam int JF_W  = VAN_W + FAC_W;
	localparam int J_W   = JF_W - REST_W;
	localparam int DVP_W = J_W + Q_W;
	localparam int DV_W  = DVP_W - FRAC_BITS;
	localparam int SHP_W = RF_W + Q_W;

	function automatic logic signed [OFF_W-1:0] nearest_off(
		input word_t             c,
		input word_t             b,
		input logic [HALF_W-1:0] half
	);
		logic signed [OFF_W-1:0] ce;
		logic signed [OFF_W-1:0] be;
		logic signed [OFF_W-1:0] he;
		logic signed [OFF_W-1:0] lo;
		logic signed [OFF_W-1:0] hi;
		logic signed [OFF_W-1:0] p;
		ce = OFF_W'(c);
		be = OFF_W'(b);
		he = signed'(OFF_W'(half));
		lo = be - he;
		hi = be + he;
		p  = (ce < lo) ? lo : ((ce > hi) ? hi : ce);
		return ce - p;
	endfunction

	// ------------------------------------------------------------------
	// Restitution register. Written only while the pipeline is empty, so the impulse
	// stage can read it directly; the user must ensure it, the block does not enforce it.
	// ------------------------------------------------------------------
	logic [REST_W-1:0] restitution_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= REST_RESET;
		end else if (cfg.valid) begin
			restitution_q <= cfg.restitution;
		end
	end

	// ------------------------------------------------------------------
	// Stall chain. Each stage loads when it is empty or the stage after it
	// moves, so bubbles collapse and a waiting result does not freeze the
	// whole pipeline.
	// ------------------------------------------------------------------
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic sq_in_ready, sq_out_valid, dv_in_ready, dv_out_valid;

	assign en_s8 = !v_s8 || result.ready;
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || sq_in_ready;
	assign en_s1 = !v_s1 || en_s2;

	assign item.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= item.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= dv_out_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: clamp the circle centre into the square and take the offset.
	// Any offset component of 2^28 or more rules out an overlap, because
	// the radius is below 2^28 in fixed point; such pairs are marked far and
	// the narrower magnitudes carried on are then don't-care.
	// ------------------------------------------------------------------
	logic signed [OFF_W-1:0] dx_c, dy_c;
	logic [OFF_W-1:0]        adx_c, ady_c;
	body_t                   body_s1;
	logic                    far_s1;

	always_comb begin
		dx_c  = nearest_off(item.circle_x, item.box_x, item.box_half);
		dy_c  = nearest_off(item.circle_y, item.box_y, item.box_half);
		adx_c = (dx_c < 0) ? OFF_W'(-dx_c) : OFF_W'(dx_c);
		ady_c = (dy_c < 0) ? OFF_W'(-dy_c) : OFF_W'(dy_c);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			body_s1.cx  <= item.circle_x;
			body_s1.cy  <= item.circle_y;
			body_s1.cvx <= item.circle_vx;
			body_s1.cvy <= item.circle_vy;
			body_s1.bx  <= item.box_x;
			body_s1.by  <= item.box_y;
			body_s1.bvx <= item.box_vx;
			body_s1.bvy <= item.box_vy;
			body_s1.rad <= item.circle_radius;
			body_s1.adx <= adx_c[RF_W-1:0];
			body_s1.ady <= ady_c[RF_W-1:0];
			body_s1.sdx <= dx_c < 0;
			body_s1.sdy <= dy_c < 0;
			body_s1.hit <= 1'b0;
			far_s1      <= (|adx_c[OFF_W-1:RF_W]) || (|ady_c[OFF_W-1:RF_W]);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: squared distance and squared radius.
	// ------------------------------------------------------------------
	body_t                  body_s2;
	logic                   far_s2;
	logic [D2_W:0]          d2_s2;
	logic [2*RAD_IN_W-1:0]  rr_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			body_s2 <= body_s1;
			far_s2  <= far_s1;
			d2_s2   <= (D2_W+1)'(D2_W'(body_s1.adx) * D2_W'(body_s1.adx))
			         + (D2_W+1)'(D2_W'(body_s1.ady) * D2_W'(body_s1.ady));
			rr_s2   <= (2*RAD_IN_W)'(body_s1.rad) * (2*RAD_IN_W)'(body_s1.rad);
		end
	end

	// Overlap means the nearest point lies strictly inside the circle.
	body_t sq_side;

	always_comb begin
		sq_side     = body_s2;
		sq_side.hit = !far_s2
		           && (d2_s2 < (D2_W+1)'({rr_s2, {(2*FRAC_BITS){1'b0}}}));
	end

	// ------------------------------------------------------------------
	// Distance: floor of the square root of the squared distance.
	// ------------------------------------------------------------------
	logic [RF_W-1:0] sq_root;
	body_t           sq_body;

	cbcr_sqrt #(
		.side_t (body_t)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (sq_in_ready),
		.rad       (d2_s2[D2_W-1:0]),
		.in_side   (sq_side),
		.out_valid (sq_out_valid),
		.out_ready (dv_in_ready),
		.root      (sq_root),
		.out_side  (sq_body)
	);

	// ------------------------------------------------------------------
	// Unit normal magnitudes: offset scaled up by the fraction width and
	// divided by the distance. The offset never exceeds the distance, so
	// each quotient fits in FRAC_BITS+1 bits.
	// ------------------------------------------------------------------
	logic [Q_W-1:0]  dv_qx, dv_qy;
	logic [RF_W-1:0] dv_den;
	body_t           dv_body;

	cbcr_div #(
		.side_t (body_t)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_out_valid),
		.in_ready  (dv_in_ready),
		.num_x     (sq_body.adx),
		.num_y     (sq_body.ady),
		.den       (sq_root),
		.in_side   (sq_body),
		.out_valid (dv_out_valid),
		.out_ready (en_s3),
		.quo_x     (dv_qx),
		.quo_y     (dv_qy),
		.out_den   (dv_den),
		.out_side  (dv_body)
	);

	// ------------------------------------------------------------------
	// Stage 3: pick the normal (straight up when the centre sits inside
	// the square), penetration depth and relative velocity.
	// ------------------------------------------------------------------
	body_t                  body_s3;
	logic [Q_W-1:0]         qx_s3, qy_s3;
	logic                   nsx_s3, nsy_s3;
	logic [RF_W-1:0]        pen_s3;
	logic signed [RV_W-1:0] rvx_s3, rvy_s3;
	logic                   inside_c;

	assign inside_c = dv_den == '0;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			body_s3 <= dv_body;
			qx_s3   <= inside_c ? '0 : dv_qx;
			qy_s3   <= inside_c ? Q_W'(1 << FRAC_BITS) : dv_qy;
			nsx_s3  <= !inside_c && dv_body.sdx;
			nsy_s3  <= !inside_c && dv_body.sdy;
			pen_s3  <= {dv_body.rad, {FRAC_BITS{1'b0}}} - dv_den;
			rvx_s3  <= RV_W'(dv_body.cvx) - RV_W'(dv_body.bvx);
			rvy_s3  <= RV_W'(dv_body.cvy) - RV_W'(dv_body.bvy);
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: separation products and normal-velocity products.
	// ------------------------------------------------------------------
	body_t                  body_s4;
	logic [Q_W-1:0]         qx_s4, qy_s4;
	logic                   nsx_s4, nsy_s4;
	logic [SHP_W-1:0]       shpx_s4, shpy_s4;
	logic signed [SV_W-1:0] svx_s4, svy_s4;
	logic signed [NS_W-1:0] nx_c, ny_c;

	always_comb begin
		nx_c = nsx_s3 ? -signed'({1'b0, qx_s3}) : signed'({1'b0, qx_s3});
		ny_c = nsy_s3 ? -signed'({1'b0, qy_s3}) : signed'({1'b0, qy_s3});
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			body_s4 <= body_s3;
			qx_s4   <= qx_s3;
			qy_s4   <= qy_s3;
			nsx_s4  <= nsx_s3;
			nsy_s4  <= nsy_s3;
			shpx_s4 <= SHP_W'(qx_s3) * SHP_W'(pen_s3);
			shpy_s4 <= SHP_W'(qy_s3) * SHP_W'(pen_s3);
			svx_s4  <= SV_W'(rvx_s3) * SV_W'(nx_c);
			svy_s4  <= SV_W'(rvy_s3) * SV_W'(ny_c);
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: move each body by half the penetration and decide whether
	// the pair is approaching. Positions are final from here on.
	// ------------------------------------------------------------------
	body_t                   body_s5;
	logic [Q_W-1:0]          qx_s5, qy_s5;
	logic                    nsx_s5, nsy_s5;
	logic                    hit_s5, imp_s5;
	logic [VAN_W-1:0]        van_s5;
	logic [FAC_W-1:0]        fac_s5;
	word_t                   ncx_s5, ncy_s5, nbx_s5, nby_s5;

	logic [RF_W-1:0]         shx_c, shy_c;
	logic signed [RF_W:0]    shsx_c, shsy_c;
	logic signed [S_W-1:0]   s_c;
	logic [S_W-1:0]          abs_s_c;
	logic [REST_W-1:0]       e_c;

	always_comb begin
		shx_c   = shpx_s4[SHP_W-1:FRAC_BITS+1];
		shy_c   = shpy_s4[SHP_W-1:FRAC_BITS+1];
		shsx_c  = nsx_s4 ? -signed'({1'b0, shx_c}) : signed'({1'b0, shx_c});
		shsy_c  = nsy_s4 ? -signed'({1'b0, shy_c}) : signed'({1'b0, shy_c});
		s_c     = S_W'(svx_s4) + S_W'(svy_s4);
		abs_s_c = (s_c < 0) ? S_W'(-s_c) : S_W'(s_c);
		e_c     = (restitution_q > REST_ONE) ? REST_ONE : restitution_q;
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			body_s5 <= body_s4;
			qx_s5   <= qx_s4;
			qy_s5   <= qy_s4;
			nsx_s5  <= nsx_s4;
			nsy_s5  <= nsy_s4;
			hit_s5  <= body_s4.hit;
			imp_s5  <= body_s4.hit && (s_c <= 0);
			van_s5  <= abs_s_c[S_W-2:FRAC_BITS];
			fac_s5  <= FAC_W'(REST_ONE) + FAC_W'(e_c);
			if (body_s4.hit) begin
				ncx_s5 <= sat_word(SAT_W'(body_s4.cx) + SAT_W'(shsx_c));
				ncy_s5 <= sat_word(SAT_W'(body_s4.cy) + SAT_W'(shsy_c));
				nbx_s5 <= sat_word(SAT_W'(body_s4.bx) - SAT_W'(shsx_c));
				nby_s5 <= sat_word(SAT_W'(body_s4.by) - SAT_W'(shsy_c));
			end else begin
				ncx_s5 <= body_s4.cx;
				ncy_s5 <= body_s4.cy;
				nbx_s5 <= body_s4.bx;
				nby_s5 <= body_s4.by;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: impulse magnitude times (1 + restitution).
	// ------------------------------------------------------------------
	body_t             body_s6;
	logic [Q_W-1:0]    qx_s6, qy_s6;
	logic              nsx_s6, nsy_s6, hit_s6, imp_s6;
	logic [JF_W-1:0]   jf_s6;
	word_t             ncx_s6, ncy_s6, nbx_s6, nby_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			body_s6 <= body_s5;
			qx_s6   <= qx_s5;
			qy_s6   <= qy_s5;
			nsx_s6  <= nsx_s5;
			nsy_s6  <= nsy_s5;
			hit_s6  <= hit_s5;
			imp_s6  <= imp_s5;
			jf_s6   <= JF_W'(van_s5) * JF_W'(fac_s5);
			ncx_s6  <= ncx_s5;
			ncy_s6  <= ncy_s5;
			nbx_s6  <= nbx_s5;
			nby_s6  <= nby_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: the equal-mass halving and Q0.16 scale drop together as one
	// shift, then the impulse is projected onto each normal component.
	// ------------------------------------------------------------------
	body_t             body_s7;
	logic              nsx_s7, nsy_s7, hit_s7, imp_s7;
	logic [DVP_W-1:0]  dvpx_s7, dvpy_s7;
	word_t             ncx_s7, ncy_s7, nbx_s7, nby_s7;
	logic [J_W-1:0]    j_c;

	assign j_c = jf_s6[JF_W-1:REST_W];

	always_ff @(posedge clk) begin
		if (en_s7) begin
			body_s7 <= body_s6;
			nsx_s7  <= nsx_s6;
			nsy_s7  <= nsy_s6;
			hit_s7  <= hit_s6;
			imp_s7  <= imp_s6;
			dvpx_s7 <= DVP_W'(j_c) * DVP_W'(qx_s6);
			dvpy_s7 <= DVP_W'(j_c) * DVP_W'(qy_s6);
			ncx_s7  <= ncx_s6;
			ncy_s7  <= ncy_s6;
			nbx_s7  <= nbx_s6;
			nby_s7  <= nby_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: apply the velocity change and hold the result word. Pairs
	// that are separating, or do not touch, keep their velocities.
	// ------------------------------------------------------------------
	word_t ncx_s8, ncy_s8, ncvx_s8, ncvy_s8;
	word_t nbx_s8, nby_s8, nbvx_s8, nbvy_s8;
	logic  hit_s8, imp_s8;

	logic [DV_W-1:0]      dvx_c, dvy_c;
	logic signed [DV_W:0] dvsx_c, dvsy_c;

	always_comb begin
		dvx_c  = dvpx_s7[DVP_W-1:FRAC_BITS];
		dvy_c  = dvpy_s7[DVP_W-1:FRAC_BITS];
		dvsx_c = nsx_s7 ? -signed'({1'b0, dvx_c}) : signed'({1'b0, dvx_c});
		dvsy_c = nsy_s7 ? -signed'({1'b0, dvy_c}) : signed'({1'b0, dvy_c});
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			ncx_s8 <= ncx_s7;
			ncy_s8 <= ncy_s7;
			nbx_s8 <= nbx_s7;
			nby_s8 <= nby_s7;
			hit_s8 <= hit_s7;
			imp_s8 <= imp_s7;
			if (imp_s7) begin
				ncvx_s8 <= sat_word(SAT_W'(body_s7.cvx) + SAT_W'(dvsx_c));
				ncvy_s8 <= sat_word(SAT_W'(body_s7.cvy) + SAT_W'(dvsy_c));
				nbvx_s8 <= sat_word(SAT_W'(body_s7.bvx) - SAT_W'(dvsx_c));
				nbvy_s8 <= sat_word(SAT_W'(body_s7.bvy) - SAT_W'(dvsy_c));
			end else begin
				ncvx_s8 <= body_s7.cvx;
				ncvy_s8 <= body_s7.cvy;
				nbvx_s8 <= body_s7.bvx;
				nbvy_s8 <= body_s7.bvy;
			end
		end
	end

	assign result.valid           = v_s8;
	assign result.new_circle_x    = ncx_s8;
	assign result.new_circle_y    = ncy_s8;
	assign result.new_circle_vx   = ncvx_s8;
	assign result.new_circle_vy   = ncvy_s8;
	assign result.new_box_x       = nbx_s8;
	assign result.new_box_y       = nby_s8;
	assign result.new_box_vx      = nbvx_s8;
	assign result.new_box_vy      = nbvy_s8;
	assign result.overlap         = hit_s8;
	assign result.impulse_applied = imp_s8;

endmodule

FILE: verif/tb_circle_box_collision_resolve.sv
module tb_circle_box_collision_resolve;
	import cbcr_pkg::*;

	// Every quiet period waits longer than the block takes to turn an accepted
	// word into its result word.
	localparam int PIPE_DEPTH  = 53;
	localparam int SETTLE      = PIPE_DEPTH + 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int STALL_LEN   = 300;
	localparam int IDLE_PCT    = 33;
	localparam int SHOWN_MAX   = 10;

	// One circle-and-square pair as it goes into the block.
	typedef struct {
		word_t               cx;
		word_t               cy;
		word_t               cvx;
		word_t               cvy;
		logic [RAD_IN_W-1:0] rad;
		word_t               bx;
		word_t               by;
		logic [HALF_W-1:0]   half;
		word_t               bvx;
		word_t               bvy;
	} pair_t;

	// What the block should hand back for that pair.
	typedef struct {
		word_t ncx;
		word_t ncy;
		word_t ncvx;
		word_t ncvy;
		word_t nbx;
		word_t nby;
		word_t nbvx;
		word_t nbvy;
		logic  hit;
		logic  imp;
	} resolved_t;

	logic clk;
	logic arst_n;

	cbcr_item_if   item_bus ();
	cbcr_result_if res_bus ();
	cbcr_cfg_if    cfg_bus ();

	circle_box_collision_resolve uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (res_bus),
		.cfg    (cfg_bus)
	);

	// Our own copy of the bounce coefficient, updated whenever we write it.
	logic [REST_W-1:0] bounce_coef;

	// Resolutions waiting for the block to produce them, oldest first.
	resolved_t pending_resolutions[$];

	int  mismatches = 0;
	int  cycle_count = 0;
	bit  steady;      // when set, neither side idles
	bit  stall_go;    // request for one long hold-off on the result side
	logic holding;    // high while that hold-off is in progress

	// Clock with an 8-unit period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The run is cut off if it drags on far beyond what a correct block needs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor. All arithmetic is done in 64-bit or 128-bit integers that
	// are wide enough to stay exact, then saturated back to a word.
	// ------------------------------------------------------------------
	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint signed_by(bit neg, longint unsigned m);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic word_t clamp_word(longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return word_t'(v);
	endfunction

	// Floor of the square root, bit by bit from the top.
	function automatic longint unsigned floor_root(bit [127:0] v);
		bit [127:0] root;
		bit [127:0] trial;
		root = '0;
		for (int b = 34; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (!(v < trial * trial)) begin
				root = trial;
			end
		end
		return root[63:0];
	endfunction

	function automatic resolved_t resolve_pair(pair_t p, logic [REST_W-1:0] coef);
		resolved_t       o;
		longint          cx, cy, cvx, cvy, bx, by, bvx, bvy, half;
		longint          px, py, dx, dy, nx, ny, sxv, syv, slide, dvx, dvy;
		longint unsigned adx, ady, rf, dlen, pen, e, van, j;
		bit [127:0]      d2, rf2;

		cx   = longint'(p.cx);
		cy   = longint'(p.cy);
		cvx  = longint'(p.cvx);
		cvy  = longint'(p.cvy);
		bx   = longint'(p.bx);
		by   = longint'(p.by);
		bvx  = longint'(p.bvx);
		bvy  = longint'(p.bvy);
		half = longint'({33'd0, p.half});

		o.hit = 1'b0;
		o.imp = 1'b0;

		// Nearest point of the square to the circle centre.
		px = (cx < bx - half) ? bx - half : ((cx > bx + half) ? bx + half : cx);
		py = (cy < by - half) ? by - half : ((cy > by + half) ? by + half : cy);
		dx = cx - px;
		dy = cy - py;
		adx = magnitude(dx);
		ady = magnitude(dy);
		d2  = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
		rf  = longint'({52'd0, p.rad}) << FRAC_BITS;
		rf2 = 128'(rf) * 128'(rf);

		if (d2 < rf2) begin
			o.hit = 1'b1;
			dlen = floor_root(d2);
			if (dlen > 0) begin
				nx = signed_by(dx < 0, (adx << FRAC_BITS) / dlen);
				ny = signed_by(dy < 0, (ady << FRAC_BITS) / dlen);
			end else begin
				// Centre inside the square: push the circle straight up and the box down, half the radius each.
				nx = 0;
				ny = longint'(1) << FRAC_BITS;
			end
			pen = rf - dlen;
			sxv = signed_by(nx < 0, (magnitude(nx) * pen) >> (FRAC_BITS + 1));
			syv = signed_by(ny < 0, (magnitude(ny) * pen) >> (FRAC_BITS + 1));
			cx = cx + sxv;
			cy = cy + syv;
			bx = bx - sxv;
			by = by - syv;

			// Relative velocity along the normal; only approaching bodies bounce.
			slide = (cvx - bvx) * nx + (cvy - bvy) * ny;
			if (slide <= 0) begin
				o.imp = 1'b1;
				e   = (coef > REST_ONE) ? 64'(REST_ONE) : 64'(coef);
				van = magnitude(slide) >> FRAC_BITS;
				j   = (van * (64'd65536 + e)) >> 17;
				dvx = signed_by(nx < 0, (j * magnitude(nx)) >> FRAC_BITS);
				dvy = signed_by(ny < 0, (j * magnitude(ny)) >> FRAC_BITS);
				cvx = cvx + dvx;
				cvy = cvy + dvy;
				bvx = bvx - dvx;
				bvy = bvy - dvy;
			end
		end

		o.ncx  = clamp_word(cx);
		o.ncy  = clamp_word(cy);
		o.ncvx = clamp_word(cvx);
		o.ncvy = clamp_word(cvy);
		o.nbx  = clamp_word(bx);
		o.nby  = clamp_word(by);
		o.nbvx = clamp_word(bvx);
		o.nbvy = clamp_word(bvy);
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Driving the item channel. Valid stays high across back-to-back words;
	// it only drops when the sender decides to idle before the next word or waits for all results.
	// ------------------------------------------------------------------
	task automatic send_pair(pair_t p);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_bus.valid         <= 1'b1;
		item_bus.circle_x      <= p.cx;
		item_bus.circle_y      <= p.cy;
		item_bus.circle_vx     <= p.cvx;
		item_bus.circle_vy     <= p.cvy;
		item_bus.circle_radius <= p.rad;
		item_bus.box_x         <= p.bx;
		item_bus.box_y         <= p.by;
		item_bus.box_half      <= p.half;
		item_bus.box_vx        <= p.bvx;
		item_bus.box_vy        <= p.bvy;
		do @(posedge clk); while (!item_bus.ready);
		pending_resolutions.push_back(resolve_pair(p, bounce_coef));
	endtask

	// Drop valid and wait until the block has delivered everything it owes.
	task automatic wait_all_resolved();
		item_bus.valid <= 1'b0;
		while (pending_resolutions.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Registers are only touched while the pipeline is empty.
	task automatic write_bounce(logic [REST_W-1:0] v);
		wait_all_resolved();
		cfg_bus.valid       <= 1'b1;
		cfg_bus.restitution <= v;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		bounce_coef = v;
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure, plus one long hold-off on request.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else if (holding) begin
			res_bus.ready <= 1'b0;
		end else if (steady) begin
			res_bus.ready <= 1'b1;
		end else begin
			res_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// One hold-off per request; the requester withdraws the request once its
	// traffic has gone through.
	initial begin
		holding = 1'b0;
		forever begin
			wait (stall_go);
			@(posedge clk);
			holding <= 1'b1;
			repeat (STALL_LEN) @(posedge clk);
			holding <= 1'b0;
			wait (!stall_go);
		end
	end

	// Every accepted result word is matched against the oldest prediction.
	always @(posedge clk) begin
		resolved_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_resolutions.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= SHOWN_MAX) begin
					$display("unexpected result word at cycle %0d", cycle_count);
				end
			end else begin
				want = pending_resolutions.pop_front();
				if (res_bus.new_circle_x !== want.ncx || res_bus.new_circle_y !== want.ncy
						|| res_bus.new_circle_vx !== want.ncvx
						|| res_bus.new_circle_vy !== want.ncvy
						|| res_bus.new_box_x !== want.nbx || res_bus.new_box_y !== want.nby
						|| res_bus.new_box_vx !== want.nbvx
						|| res_bus.new_box_vy !== want.nbvy
						|| res_bus.overlap !== want.hit
						|| res_bus.impulse_applied !== want.imp) begin
					mismatches = mismatches + 1;
					if (mismatches <= SHOWN_MAX) begin
						$display("mismatch at cycle %0d", cycle_count);
						$display("  circle pos exp %0d %0d got %0d %0d", want.ncx, want.ncy,
							res_bus.new_circle_x, res_bus.new_circle_y);
						$display("  circle vel exp %0d %0d got %0d %0d", want.ncvx,
							want.ncvy, res_bus.new_circle_vx, res_bus.new_circle_vy);
						$display("  box pos    exp %0d %0d got %0d %0d", want.nbx, want.nby,
							res_bus.new_box_x, res_bus.new_box_y);
						$display("  box vel    exp %0d %0d got %0d %0d", want.nbvx,
							want.nbvy, res_bus.new_box_vx, res_bus.new_box_vy);
						$display("  flags      exp %b%b got %b%b", want.hit, want.imp,
							res_bus.overlap, res_bus.impulse_applied);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Pair builders.
	// ------------------------------------------------------------------
	function automatic word_t any_word();
		return word_t'($urandom);
	endfunction

	// A pair in general position: every bit of every field is random.
	function automatic pair_t noise_pair();
		pair_t p;
		p.cx   = any_word();
		p.cy   = any_word();
		p.cvx  = any_word();
		p.cvy  = any_word();
		p.rad  = RAD_IN_W'($urandom);
		p.bx   = any_word();
		p.by   = any_word();
		p.half = HALF_W'($urandom);
		p.bvx  = any_word();
		p.bvy  = any_word();
		return p;
	endfunction

	// A pair placed so that the circle sits around the square's edge, which is
	// where overlap, separation and the impulse actually get exercised.
	function automatic pair_t touching_pair();
		pair_t  p;
		longint span, ox, oy, cvel;
		p.bx   = word_t'($urandom_range(0, 32'h1fffffff)) - 32'sh10000000;
		p.by   = word_t'($urandom_range(0, 32'h1fffffff)) - 32'sh10000000;
		p.half = HALF_W'($urandom_range(0, 32'h003fffff));
		if ($urandom_range(0, 19) == 0) begin
			p.rad = RAD_IN_W'($urandom_range(0, 4095));
		end else begin
			p.rad = RAD_IN_W'($urandom_range(0, 63));
		end
		span = longint'({33'd0, p.half}) + (longint'({52'd0, p.rad}) << FRAC_BITS)
			+ 65536;
		ox = longint'($urandom_range(0, 32'(2 * span))) - span;
		oy = longint'($urandom_range(0, 32'(2 * span))) - span;
		p.cx = word_t'(longint'(p.bx) + ox);
		p.cy = word_t'(longint'(p.by) + oy);
		// Mostly moderate speeds, sometimes anything at all.
		cvel = ($urandom_range(0, 7) == 0) ? 32'hffffffff : 32'h07ffffff;
		p.cvx = word_t'($urandom_range(0, 32'(cvel))) - word_t'(cvel >> 1);
		p.cvy = word_t'($urandom_range(0, 32'(cvel))) - word_t'(cvel >> 1);
		p.bvx = word_t'($urandom_range(0, 32'(cvel))) - word_t'(cvel >> 1);
		p.bvy = word_t'($urandom_range(0, 32'(cvel))) - word_t'(cvel >> 1);
		return p;
	endfunction

	// Mostly well-placed pairs, with some pure noise mixed in.
	task automatic send_random_pairs(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 80) begin
				send_pair(touching_pair());
			end else begin
				send_pair(noise_pair());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Hand-picked pairs for the corners of the behavior, at the reset
	// restitution.
	task automatic test_special_cases();
		pair_t p;
		// Far apart: everything passes through untouched.
		p = '{cx: 32'sd0, cy: 32'sd0, cvx: 32'sd65536, cvy: -32'sd65536, rad: 12'd2,
			bx: 32'sd10 << 16, by: 32'sd0, half: 31'd65536, bvx: 32'sd0, bvy: 32'sd0};
		send_pair(p);
		// Zero radius right on top of the square never overlaps.
		p.rad = 12'd0;
		p.bx  = 32'sd0;
		send_pair(p);
		// Centre inside the square: normal points straight up.
		p.rad = 12'd3;
		send_pair(p);
		// Approaching head-on along x.
		p = '{cx: -(32'sd2 << 16), cy: 32'sd0, cvx: 32'sd5 << 16, cvy: 32'sd0, rad: 12'd2,
			bx: 32'sd0, by: 32'sd0, half: 31'd65536, bvx: -(32'sd1 << 16), bvy: 32'sd0};
		send_pair(p);
		// Same geometry, moving apart: separation only.
		p.cvx = -(32'sd5 << 16);
		send_pair(p);
		// Moving only along the contact face: zero normal speed still counts.
		p.cvx = 32'sd0;
		p.bvx = 32'sd0;
		p.cvy = 32'sd7 << 16;
		send_pair(p);
		// Diagonal corner contact.
		p = '{cx: 32'sd90000, cy: 32'sd90000, cvx: -32'sd70000, cvy: -32'sd30000,
			rad: 12'd1, bx: 32'sd0, by: 32'sd0, half: 31'd65536, bvx: 32'sd0, bvy: 32'sd0};
		send_pair(p);
		// Positions near the top of the range: the push saturates.
		p = '{cx: 32'sh7fff0000, cy: 32'sh7fff0000, cvx: 32'sh7fffffff,
			cvy: 32'sh7fffffff, rad: 12'd4095, bx: 32'sh7ffe0000, by: 32'sh7ffe0000,
			half: 31'd0, bvx: 32'sh80000000, bvy: 32'sh80000000};
		send_pair(p);
		// Mirror image at the bottom of the range.
		p = '{cx: 32'sh80000000, cy: 32'sh80000000, cvx: 32'sh80000000,
			cvy: 32'sh80000000, rad: 12'd4095, bx: 32'sh80010000, by: 32'sh80010000,
			half: 31'd0, bvx: 32'sh7fffffff, bvy: 32'sh7fffffff};
		send_pair(p);
		// Largest square and largest radius, centre inside.
		p = '{cx: 32'sd0, cy: 32'sd0, cvx: 32'sh80000000, cvy: 32'sh80000000,
			rad: 12'd4095, bx: 32'sd0, by: 32'sd0, half: 31'h7fffffff,
			bvx: 32'sh7fffffff, bvy: 32'sh7fffffff};
		send_pair(p);
		// All fields at their lowest and at their highest.
		p = '{cx: 32'sh80000000, cy: 32'sh80000000, cvx: 32'sh80000000,
			cvy: 32'sh80000000, rad: 12'd0, bx: 32'sh80000000, by: 32'sh80000000,
			half: 31'd0, bvx: 32'sh80000000, bvy: 32'sh80000000};
		send_pair(p);
		p = '{cx: 32'sh7fffffff, cy: 32'sh7fffffff, cvx: 32'sh7fffffff,
			cvy: 32'sh7fffffff, rad: 12'd4095, bx: 32'sh7fffffff, by: 32'sh7fffffff,
			half: 31'h7fffffff, bvx: 32'sh7fffffff, bvy: 32'sh7fffffff};
		send_pair(p);
		// Opposite corners of the number line with a huge square in between.
		p.cx = 32'sh80000000;
		p.bvx = 32'sh80000000;
		send_pair(p);
		// Just touching: distance equal to the radius is not an overlap.
		p = '{cx: 32'sd2 << 16, cy: 32'sd0, cvx: -(32'sd1 << 16), cvy: 32'sd0, rad: 12'd1,
			bx: 32'sd0, by: 32'sd0, half: 31'd65536, bvx: 32'sd0, bvy: 32'sd0};
		send_pair(p);
		p.cx = (32'sd2 << 16) - 1;
		send_pair(p);
		wait_all_resolved();
	endtask

	// Random traffic at a range of bounce settings, including both ends of
	// the register and values above 1.0 that must saturate.
	task automatic test_bounce_settings();
		logic [REST_W-1:0] settings[5];
		settings[0] = REST_W'(0);
		settings[1] = REST_ONE;
		settings[2] = {REST_W{1'b1}};
		settings[3] = REST_W'($urandom);
		settings[4] = REST_RESET;
		send_random_pairs(100);
		foreach (settings[k]) begin
			write_bounce(settings[k]);
			send_random_pairs(100);
		end
		wait_all_resolved();
	endtask

	// A long stretch with no idling on either side.
	task automatic test_full_rate();
		steady = 1'b1;
		send_random_pairs(150);
		steady = 1'b0;
		wait_all_resolved();
	endtask

	// The result side holds off for a long time while pairs keep coming, so
	// the pipeline fills and the input stalls; then the sender waits until
	// everything is out before carrying on.
	task automatic test_output_stall();
		stall_go = 1'b1;
		send_random_pairs(150);
		stall_go = 1'b0;
		wait_all_resolved();
		send_random_pairs(20);
		wait_all_resolved();
	endtask

	initial begin
		arst_n                 = 1'b0;
		item_bus.valid         = 1'b0;
		item_bus.circle_x      = '0;
		item_bus.circle_y      = '0;
		item_bus.circle_vx     = '0;
		item_bus.circle_vy     = '0;
		item_bus.circle_radius = '0;
		item_bus.box_x         = '0;
		item_bus.box_y         = '0;
		item_bus.box_half      = '0;
		item_bus.box_vx        = '0;
		item_bus.box_vy        = '0;
		cfg_bus.valid          = 1'b0;
		cfg_bus.restitution    = '0;
		bounce_coef            = REST_RESET;
		steady                 = 1'b0;
		stall_go               = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_bounce_settings();
		test_full_rate();
		test_output_stall();

		if (mismatches == 0 && pending_resolutions.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: circle_box_collision_resolve.f
src/cbcr_pkg.sv
src/cbcr_if.sv
src/cbcr_sqrt.sv
src/cbcr_div.sv
src/circle_box_collision_resolve.sv
verif/tb_circle_box_collision_resolve.sv
